// ===== hdl/jbse_pkg.sv =====
`default_nettype none
package jbse_pkg;

	localparam int unsigned SHIFT_WIDTH = 8;
	localparam int unsigned DR_BITS     = 32;
	localparam int unsigned CLK_W       = 24;
	localparam int unsigned CNT_W       = $clog2(DR_BITS);
	localparam int unsigned NBIT_W      = $clog2(SHIFT_WIDTH + 1);
	localparam int unsigned ADDR_W      = 3;

	localparam logic [CLK_W-1:0] ERASE_CLOCKS_RST = CLK_W'(600000);
	localparam logic [ADDR_W-3:0] REG_ERASE_CLOCKS = '0;

	typedef enum logic [2:0] {
		CMD_SHIFT_LSB = 3'd0,
		CMD_SHIFT_MSB = 3'd1,
		CMD_MSB_OUT   = 3'd2,
		CMD_TMS_SHIFT = 3'd3,
		CMD_DR32      = 3'd4,
		CMD_RUN_TEST  = 3'd5,
		CMD_ERASE     = 3'd6,
		CMD_UNUSED    = 3'd7
	} cmd_t;

	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic cmd_ok;
		logic step_last;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/jbse_ctrl.sv =====
`default_nettype none
module jbse_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire jbse_pkg::dp_stat_t stat,
	output jbse_pkg::dp_cmd_t      cmd
);
	import jbse_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SHIFT = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	assign cmd.load = in_valid && (state_q == ST_IDLE);
	assign cmd.step = (state_q == ST_SHIFT) && slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				// unused codes are taken and dropped
				if (cmd.load && stat.cmd_ok)
					state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (cmd.step && stat.step_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/jbse_dp.sv =====
`default_nettype none
module jbse_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire jbse_pkg::dp_cmd_t           cmd,
	output jbse_pkg::dp_stat_t               stat,
	input  wire logic [2:0]                  command,
	input  wire logic [7:0]                  tdi_byte,
	input  wire logic [3:0]                  bit_count,
	input  wire logic [31:0]                 dr_word,
	input  wire logic [7:0]                  dr_tail,
	input  wire logic [jbse_pkg::CLK_W-1:0]  clock_count,
	input  wire logic [7:0]                  tdo_samples,
	input  wire logic [jbse_pkg::CLK_W-1:0]  erase_clocks,
	output logic [jbse_pkg::CLK_W-1:0]       tck_pulses,
	output logic                             tdi_level,
	output logic                             tms_level,
	output logic [7:0]                       reply,
	output logic                             last
);
	import jbse_pkg::*;

	cmd_t              cmd_q;
	logic [7:0]        data_q;
	logic [NBIT_W-1:0] n_q;
	logic [31:0]       word_q;
	logic [7:0]        tail_q;
	logic [7:0]        tdo_q;
	logic [CLK_W-1:0]  clocks_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [7:0]        reply_q;
	logic              tdi_hold_q;
	logic              tms_hold_q;

	logic [CLK_W-1:0]  tck_q;
	logic              tdi_out_q;
	logic              tms_out_q;
	logic [7:0]        reply_out_q;
	logic              last_out_q;

	logic [2:0]        bit_idx;
	logic              tdo_bit;
	logic              fin;
	logic [CLK_W-1:0]  pulses_d;
	logic              tdi_d;
	logic              tms_d;
	logic [7:0]        reply_d;
	logic              capture;

	assign bit_idx = cnt_q[2:0];
	assign tdo_bit = tdo_q[bit_idx];
	assign capture = (cmd_q != CMD_MSB_OUT);

	assign stat.cmd_ok    = (cmd_t'(command) != CMD_UNUSED);
	assign stat.step_last = fin;

	// next pulse, derived from the latched command and the pulse index
	always_comb begin
		pulses_d = CLK_W'(1);
		tdi_d    = tdi_hold_q;
		tms_d    = tms_hold_q;
		reply_d  = reply_q;
		fin      = 1'b1;
		case (cmd_q)
			CMD_SHIFT_LSB, CMD_SHIFT_MSB, CMD_MSB_OUT, CMD_TMS_SHIFT: begin
				if (cmd_q == CMD_TMS_SHIFT)
					tdi_d = data_q[7];
				if (n_q == '0) begin
					pulses_d = '0;
					fin      = 1'b1;
				end else begin
					fin = ({1'b0, cnt_q[NBIT_W-2:0]} + NBIT_W'(1)) == n_q;
					if (cmd_q == CMD_SHIFT_LSB) begin
						tdi_d   = data_q[bit_idx];
						reply_d = {tdo_bit, reply_q[7:1]};
					end else if (cmd_q == CMD_TMS_SHIFT) begin
						tms_d   = data_q[bit_idx];
						reply_d = {tdo_bit, reply_q[7:1]};
					end else begin
						tdi_d   = data_q[~bit_idx];
						reply_d = {reply_q[6:0], tdo_bit};
					end
				end
			end
			CMD_DR32: begin
				fin = (cnt_q == CNT_W'(DR_BITS - 1));
				if (fin) begin
					tdi_d = tail_q[7];
					tms_d = tail_q[0];
				end else begin
					// bit 31 - i of the word
					tdi_d = word_q[~cnt_q];
					tms_d = 1'b0;
				end
			end
			default: begin
				pulses_d = clocks_q;
				tdi_d    = 1'b0;
				tms_d    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tdi_hold_q <= 1'b0;
			tms_hold_q <= 1'b0;
		end else if (cmd.step) begin
			tdi_hold_q <= tdi_d;
			tms_hold_q <= tms_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= cmd_t'(command);
			data_q   <= tdi_byte;
			n_q      <= (bit_count > 4'(SHIFT_WIDTH)) ? NBIT_W'(SHIFT_WIDTH)
			                                         : NBIT_W'(bit_count);
			word_q   <= dr_word;
			tail_q   <= dr_tail;
			tdo_q    <= tdo_samples;
			clocks_q <= (cmd_t'(command) == CMD_ERASE) ? erase_clocks : clock_count;
			cnt_q    <= '0;
			reply_q  <= '0;
		end else if (cmd.step) begin
			cnt_q   <= cnt_q + CNT_W'(1);
			reply_q <= reply_d;
		end
		if (cmd.step) begin
			tck_q       <= pulses_d;
			tdi_out_q   <= tdi_d;
			tms_out_q   <= tms_d;
			reply_out_q <= (fin && capture && (n_q != '0) && (cmd_q <= CMD_TMS_SHIFT))
			               ? reply_d : 8'h00;
			last_out_q  <= fin;
		end
	end

	assign tck_pulses = tck_q;
	assign tdi_level  = tdi_out_q;
	assign tms_level  = tms_out_q;
	assign reply      = reply_out_q;
	assign last       = last_out_q;

endmodule
`default_nettype wire

// ===== hdl/jtag_bit_shift_engine.sv =====
`default_nettype none
// channel  | handshake               | payload
// ---------+-------------------------+------------------------------------------
// in       | in_valid / in_stall     | command tdi_byte bit_count dr_word
//          |                         | dr_tail clock_count tdo_samples
// out      | out_valid / out_stall   | tck_pulses tdi_level tms_level reply last
// apb      | psel penable pwrite ... | erase_clocks at byte address 0
//
// a command is loaded while idle and then gives one result per cycle while the
// output register is free: n results for shifts (one if n is zero), 32 for the
// dr32 program, one for run-test and erase; an unused code is taken and dropped
// with no result. in_stall stays high until the final result enters the output register
// reset clears the held tdi/tms levels and sets erase_clocks to 600000
module jtag_bit_shift_engine (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [2:0]                  command,
	input  wire logic [7:0]                  tdi_byte,
	input  wire logic [3:0]                  bit_count,
	input  wire logic [31:0]                 dr_word,
	input  wire logic [7:0]                  dr_tail,
	input  wire logic [jbse_pkg::CLK_W-1:0]  clock_count,
	input  wire logic [7:0]                  tdo_samples,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [jbse_pkg::CLK_W-1:0]       tck_pulses,
	output logic                             tdi_level,
	output logic                             tms_level,
	output logic [7:0]                       reply,
	output logic                             last,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [jbse_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import jbse_pkg::*;

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [CLK_W-1:0] erase_clocks_q;
	logic             reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1:2] == REG_ERASE_CLOCKS);
	assign prdata  = reg_hit ? {{(32 - CLK_W){1'b0}}, erase_clocks_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			erase_clocks_q <= ERASE_CLOCKS_RST;
		else if (psel && penable && pwrite && pready && reg_hit)
			erase_clocks_q <= pwdata[CLK_W-1:0];
	end

	jbse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	jbse_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.command      (command),
		.tdi_byte     (tdi_byte),
		.bit_count    (bit_count),
		.dr_word      (dr_word),
		.dr_tail      (dr_tail),
		.clock_count  (clock_count),
		.tdo_samples  (tdo_samples),
		.erase_clocks (erase_clocks_q),
		.tck_pulses   (tck_pulses),
		.tdi_level    (tdi_level),
		.tms_level    (tms_level),
		.reply        (reply),
		.last         (last)
	);

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import jbse_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASES         = 5;
	localparam int RANDOM_PER_PHASE = 41;

	typedef struct {
		cmd_t             command;
		logic [7:0]       tdi_byte;
		logic [3:0]       bit_count;
		logic [31:0]      dr_word;
		logic [7:0]       dr_tail;
		logic [CLK_W-1:0] clock_count;
		logic [7:0]       tdo_samples;
	} tap_cmd_t;

	typedef struct packed {
		logic [CLK_W-1:0] pulses;
		logic             tdi;
		logic             tms;
		logic [7:0]       reply;
		logic             last;
	} tap_pulse_t;

	class tap_pulse_board;
		tap_pulse_t       pending_pulses[$];
		logic             tdi_held;
		logic             tms_held;
		logic [CLK_W-1:0] erase_clocks;
		int               errors;

		function new();
			tdi_held     = 1'b0;
			tms_held     = 1'b0;
			erase_clocks = ERASE_CLOCKS_RST;
			errors       = 0;
		endfunction

		function void set_erase(logic [31:0] value);
			erase_clocks = value[CLK_W-1:0];
		endfunction

		function int waiting();
			return pending_pulses.size();
		endfunction

		function void miss(string what, longint unsigned want, longint unsigned got);
			errors++;
			if (errors <= 10) begin
				$display("tb: mismatch on %s: expected %0h, got %0h", what, want, got);
			end
		endfunction

		function void add_pulse(logic [CLK_W-1:0] pulses, logic [7:0] rep, logic fin);
			tap_pulse_t p;
			p.pulses = pulses;
			p.tdi    = tdi_held;
			p.tms    = tms_held;
			p.reply  = rep;
			p.last   = fin;
			pending_pulses.push_back(p);
		endfunction

		function void run_test(logic [CLK_W-1:0] clocks);
			tdi_held = 1'b0;
			tms_held = 1'b0;
			add_pulse(clocks, 8'h00, 1'b1);
		endfunction

		// works out every pulse that one accepted command should produce
		function void predict_pulses(tap_cmd_t c);
			int         n;
			int         i;
			logic [7:0] captured;
			logic       fin;
			logic       capture;
			n        = (c.bit_count > SHIFT_WIDTH) ? SHIFT_WIDTH : int'(c.bit_count);
			captured = 8'h00;
			case (c.command)
				CMD_SHIFT_LSB, CMD_SHIFT_MSB, CMD_MSB_OUT, CMD_TMS_SHIFT: begin
					capture = (c.command != CMD_MSB_OUT);
					if (c.command == CMD_TMS_SHIFT) begin
						tdi_held = c.tdi_byte[7];
					end
					if (n == 0) begin
						add_pulse('0, 8'h00, 1'b1);
					end else begin
						for (i = 0; i < n; i++) begin
							case (c.command)
								CMD_SHIFT_LSB: begin
									tdi_held = c.tdi_byte[i];
									captured = {c.tdo_samples[i], captured[7:1]};
								end
								CMD_TMS_SHIFT: begin
									tms_held = c.tdi_byte[i];
									captured = {c.tdo_samples[i], captured[7:1]};
								end
								default: begin
									tdi_held = c.tdi_byte[7-i];
									captured = {captured[6:0], c.tdo_samples[i]};
								end
							endcase
							fin = (i == n - 1);
							add_pulse(CLK_W'(1), (fin && capture) ? captured : 8'h00, fin);
						end
					end
				end
				CMD_DR32: begin
					for (i = 0; i < DR_BITS; i++) begin
						fin = (i == DR_BITS - 1);
						if (fin) begin
							tdi_held = c.dr_tail[7];
							tms_held = c.dr_tail[0];
						end else begin
							tdi_held = c.dr_word[31-i];
							tms_held = 1'b0;
						end
						add_pulse(CLK_W'(1), 8'h00, fin);
					end
				end
				CMD_RUN_TEST: run_test(c.clock_count);
				CMD_ERASE: run_test(erase_clocks);
				default: ;
			endcase
		endfunction

		function void check_pulse(tap_pulse_t got);
			tap_pulse_t want;
			if (pending_pulses.size() == 0) begin
				miss("unexpected result tck_pulses", '0, 64'(got.pulses));
				return;
			end
			want = pending_pulses.pop_front();
			if (got.pulses !== want.pulses) begin
				miss("tck_pulses", 64'(want.pulses), 64'(got.pulses));
			end
			if (got.tdi !== want.tdi) miss("tdi_level", 64'(want.tdi), 64'(got.tdi));
			if (got.tms !== want.tms) miss("tms_level", 64'(want.tms), 64'(got.tms));
			if (got.reply !== want.reply) begin
				miss("reply", 64'(want.reply), 64'(got.reply));
			end
			if (got.last !== want.last) miss("last", 64'(want.last), 64'(got.last));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        command;
	logic [7:0]        tdi_byte;
	logic [3:0]        bit_count;
	logic [31:0]       dr_word;
	logic [7:0]        dr_tail;
	logic [CLK_W-1:0]  clock_count;
	logic [7:0]        tdo_samples;
	logic              out_valid;
	logic              out_stall;
	logic [CLK_W-1:0]  tck_pulses;
	logic              tdi_level;
	logic              tms_level;
	logic [7:0]        reply;
	logic              last;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	tap_pulse_board board;
	bit             hold_req;
	bit             tx_burst;
	int             idle_cycles;

	jtag_bit_shift_engine i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.tdi_byte    (tdi_byte),
		.bit_count   (bit_count),
		.dr_word     (dr_word),
		.dr_tail     (dr_tail),
		.clock_count (clock_count),
		.tdo_samples (tdo_samples),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tck_pulses  (tck_pulses),
		.tdi_level   (tdi_level),
		.tms_level   (tms_level),
		.reply       (reply),
		.last        (last),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic tap_cmd_t mk(cmd_t cmd, logic [7:0] data, logic [3:0] bits,
			logic [31:0] word, logic [7:0] tail, logic [CLK_W-1:0] clocks,
			logic [7:0] tdo);
		tap_cmd_t c;
		c.command     = cmd;
		c.tdi_byte    = data;
		c.bit_count   = bits;
		c.dr_word     = word;
		c.dr_tail     = tail;
		c.clock_count = clocks;
		c.tdo_samples = tdo;
		return c;
	endfunction

	function automatic tap_cmd_t random_command();
		tap_cmd_t c;
		int       pick;
		cmd_t     shift_codes[4];
		shift_codes = '{CMD_SHIFT_LSB, CMD_SHIFT_MSB, CMD_MSB_OUT, CMD_TMS_SHIFT};
		pick = $urandom_range(0, 99);
		if (pick < 62) c.command = shift_codes[pick % 4];
		else if (pick < 74) c.command = CMD_DR32;
		else if (pick < 86) c.command = CMD_RUN_TEST;
		else if (pick < 95) c.command = CMD_ERASE;
		else c.command = CMD_UNUSED;
		c.tdi_byte = 8'($urandom);
		if ($urandom_range(0, 3) == 0) c.bit_count = 4'($urandom_range(0, 15));
		else c.bit_count = 4'($urandom_range(1, SHIFT_WIDTH));
		c.dr_word = $urandom;
		c.dr_tail = 8'($urandom);
		case ($urandom_range(0, 7))
			0: c.clock_count = '0;
			1: c.clock_count = '1;
			default: c.clock_count = CLK_W'($urandom);
		endcase
		c.tdo_samples = 8'($urandom);
		return c;
	endfunction

	// one input transfer; called right after a rising edge
	task automatic send(tap_cmd_t c);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= c.command;
		tdi_byte    <= c.tdi_byte;
		bit_count   <= c.bit_count;
		dr_word     <= c.dr_word;
		dr_tail     <= c.dr_tail;
		clock_count <= c.clock_count;
		tdo_samples <= c.tdo_samples;
		do @(posedge clk); while (in_stall);
		board.predict_pulses(c);
	endtask

	task automatic apb_access(input bit wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {REG_ERASE_CLOCKS, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_directed();
		send(mk(CMD_SHIFT_LSB, 8'hFF, 4'd8, '0, '0, '0, 8'h00));
		send(mk(CMD_SHIFT_LSB, 8'h00, 4'd8, '0, '0, '0, 8'hFF));
		send(mk(CMD_SHIFT_MSB, 8'hA5, 4'd8, '0, '0, '0, 8'h5A));
		send(mk(CMD_MSB_OUT, 8'h3C, 4'd8, '0, '0, '0, 8'hFF));
		send(mk(CMD_TMS_SHIFT, 8'h80, 4'd8, '0, '0, '0, 8'h81));
		send(mk(CMD_TMS_SHIFT, 8'h7F, 4'd3, '0, '0, '0, 8'hC3));
		// zero bit count keeps the held levels, but tms shift still sets tdi from bit 7
		send(mk(CMD_SHIFT_LSB, 8'h5A, 4'd0, '0, '0, '0, 8'hFF));
		send(mk(CMD_SHIFT_MSB, 8'h5A, 4'd0, '0, '0, '0, 8'hFF));
		send(mk(CMD_MSB_OUT, 8'h5A, 4'd0, '0, '0, '0, 8'hFF));
		send(mk(CMD_TMS_SHIFT, 8'h80, 4'd0, '0, '0, '0, 8'hFF));
		// counts above eight saturate
		send(mk(CMD_SHIFT_LSB, 8'h96, 4'd15, '0, '0, '0, 8'h69));
		send(mk(CMD_SHIFT_MSB, 8'h96, 4'd9, '0, '0, '0, 8'hE7));
		send(mk(CMD_TMS_SHIFT, 8'h01, 4'd1, '0, '0, '0, 8'h01));
		send(mk(CMD_DR32, 8'h00, 4'd0, 32'hFFFF_FFFF, 8'hFF, '0, 8'h00));
		send(mk(CMD_DR32, 8'hFF, 4'd8, 32'h0000_0000, 8'h00, '1, 8'hFF));
		send(mk(CMD_DR32, 8'h00, 4'd0, 32'h8000_0001, 8'h80, '0, 8'h00));
		send(mk(CMD_DR32, 8'h00, 4'd0, 32'hA5A5_A5A5, 8'h01, '0, 8'h00));
		send(mk(CMD_RUN_TEST, 8'hFF, 4'd8, '0, '0, '0, 8'h00));
		send(mk(CMD_RUN_TEST, 8'h00, 4'd0, '1, '1, '1, 8'hFF));
		send(mk(CMD_RUN_TEST, 8'h00, 4'd0, '0, '0, 24'd5, 8'h00));
		send(mk(CMD_ERASE, 8'h00, 4'd0, '0, '0, 24'd5, 8'h00));
		send(mk(CMD_UNUSED, 8'hFF, 4'd8, '1, '1, '1, 8'hFF));
		send(mk(CMD_MSB_OUT, 8'hFF, 4'd8, '0, '0, '0, 8'h00));
	endtask

	// result side: random stalls, bursts without stalls and one long hold-off
	initial begin
		int  wait_cycles;
		bit  rx_burst;
		rx_burst = 1'b0;
		out_stall <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
			wait_cycles = rx_burst ? 0 : $urandom_range(0, 14);
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			board.check_pulse({tck_pulses, tdi_level, tms_level, reply, last});
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		logic [31:0] erase_setting[PHASES];
		logic [31:0] rd;
		int          ph;
		board    = new();
		hold_req = 1'b0;
		tx_burst = 1'b0;
		erase_setting[0] = 32'(ERASE_CLOCKS_RST);
		erase_setting[1] = 32'h0000_0000;
		erase_setting[2] = 32'hFFFF_FFFF;
		erase_setting[3] = $urandom_range(1, 64);
		erase_setting[4] = $urandom;

		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		command     <= CMD_SHIFT_LSB;
		tdi_byte    <= '0;
		bit_count   <= '0;
		dr_word     <= '0;
		dr_tail     <= '0;
		clock_count <= '0;
		tdo_samples <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				// register is only touched once the block has gone quiet
				while (board.waiting() != 0) @(posedge clk);
				repeat (SETTLE_CYCLES) @(posedge clk);
				apb_access(1'b1, erase_setting[ph], rd);
				board.set_erase(erase_setting[ph]);
				@(posedge clk);
			end
			apb_access(1'b0, '0, rd);
			if (rd[CLK_W-1:0] !== board.erase_clocks) begin
				board.miss("erase_clocks readback", 64'(board.erase_clocks),
					64'(rd[CLK_W-1:0]));
			end
			if (ph == 0) run_directed();
			if (ph == 2) hold_req = 1'b1;
			send(mk(CMD_ERASE, 8'($urandom), 4'($urandom), $urandom, 8'($urandom),
				CLK_W'($urandom), 8'($urandom)));
			repeat (RANDOM_PER_PHASE) begin
				if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
				send(random_command());
			end
			in_valid <= 1'b0;
		end

		while (board.waiting() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.waiting() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
